>>> design/psw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package psw_pkg;

    localparam int MAX_JOBS_DEF = 16;

    localparam int BURST_W = 16;
    localparam int PRIO_W  = 8;
    localparam int NUM_W   = 5;
    localparam int TIME_W  = 20;

    typedef struct packed {
        logic [BURST_W-1:0] burst_len;
        logic [PRIO_W-1:0]  priority_req;
        logic               last;
    } t_in;

    typedef struct packed {
        logic [NUM_W-1:0]   job_number;
        logic [PRIO_W-1:0]  job_priority;
        logic [BURST_W-1:0] job_burst;
        logic [TIME_W-1:0]  waiting;
        logic [TIME_W-1:0]  turnaround;
        logic               overflow;
        logic               final_res;
    } t_out;

    typedef struct packed {
        logic insert;
        logic emit;
        logic final_job;
    } t_ctrl;

    typedef struct packed {
        logic one_left;
    } t_stat;

endpackage

`default_nettype wire

>>> design/psw_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module psw_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire logic          i_last,
    input  psw_pkg::t_stat     i_stat,
    output psw_pkg::t_ctrl     o_ctrl,
    output logic               busy
);
    import psw_pkg::*;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        case (r_state)
            ST_LOAD: begin
                o_ctrl.insert = start;
                if (start && i_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                o_ctrl.emit      = 1'b1;
                o_ctrl.final_job = i_stat.one_left;
                if (i_stat.one_left) begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            busy    <= 1'b0;
        end else begin
            r_state <= n_state;
            busy    <= (n_state == ST_EMIT);
        end
    end

endmodule

`default_nettype wire

>>> design/psw_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module psw_datapath #(
    parameter int MAX_JOBS = psw_pkg::MAX_JOBS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  psw_pkg::t_in       i_job,
    input  psw_pkg::t_ctrl     i_ctrl,
    output psw_pkg::t_stat     o_stat,
    output psw_pkg::t_out      o_res,
    output logic               o_res_stb
);
    import psw_pkg::*;

    localparam int IW = $clog2(MAX_JOBS);
    localparam int CW = $clog2(MAX_JOBS + 1);

    logic [PRIO_W-1:0]  r_prio  [MAX_JOBS];
    logic [BURST_W-1:0] r_burst [MAX_JOBS];
    logic [IW-1:0]      r_id    [MAX_JOBS];
    logic [MAX_JOBS-1:0] r_vld;

    logic [PRIO_W-1:0]  n_prio  [MAX_JOBS];
    logic [BURST_W-1:0] n_burst [MAX_JOBS];
    logic [IW-1:0]      n_id    [MAX_JOBS];
    logic [MAX_JOBS-1:0] n_vld;

    logic [MAX_JOBS-1:0] keep;
    logic [MAX_JOBS-1:0] prev_keep;

    logic [CW-1:0]     r_count;
    logic              r_dropped;
    logic [TIME_W-1:0] r_clock;
    logic              full;
    logic [IW:0]       num;
    logic [TIME_W-1:0] turn;

    assign full            = (r_count == CW'(MAX_JOBS));
    assign o_stat.one_left = (r_count == CW'(1));

    assign num  = {1'b0, r_id[0]} + (IW + 1)'(1);
    assign turn = r_clock + TIME_W'(r_burst[0]);

    // Each cell holds its job when that job sorts at or ahead of the new one,
    // so equal priorities stay in arrival order.
    always_comb begin
        for (int i = 0; i < MAX_JOBS; i++) begin
            keep[i] = r_vld[i] && (r_prio[i] <= i_job.priority_req);
        end
        prev_keep[0] = 1'b1;
        for (int i = 1; i < MAX_JOBS; i++) begin
            prev_keep[i] = keep[i-1];
        end

        n_prio  = r_prio;
        n_burst = r_burst;
        n_id    = r_id;
        n_vld   = r_vld;

        if (i_ctrl.insert && !full) begin
            for (int i = 0; i < MAX_JOBS; i++) begin
                if (!keep[i] && prev_keep[i]) begin
                    n_prio[i]  = i_job.priority_req;
                    n_burst[i] = i_job.burst_len;
                    n_id[i]    = r_count[IW-1:0];
                    n_vld[i]   = 1'b1;
                end
            end
            for (int i = 1; i < MAX_JOBS; i++) begin
                if (!keep[i] && !prev_keep[i]) begin
                    n_prio[i]  = r_prio[i-1];
                    n_burst[i] = r_burst[i-1];
                    n_id[i]    = r_id[i-1];
                    n_vld[i]   = r_vld[i-1];
                end
            end
        end else if (i_ctrl.emit) begin
            for (int i = 0; i < MAX_JOBS - 1; i++) begin
                n_prio[i]  = r_prio[i+1];
                n_burst[i] = r_burst[i+1];
                n_id[i]    = r_id[i+1];
                n_vld[i]   = r_vld[i+1];
            end
            n_vld[MAX_JOBS-1] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prio  <= n_prio;
        r_burst <= n_burst;
        r_id    <= n_id;
        if (i_ctrl.emit) begin
            o_res.job_number   <= NUM_W'(num);
            o_res.job_priority <= r_prio[0];
            o_res.job_burst    <= r_burst[0];
            o_res.waiting      <= r_clock;
            o_res.turnaround   <= turn;
            o_res.overflow     <= r_dropped;
            o_res.final_res    <= i_ctrl.final_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_clock   <= '0;
            o_res_stb <= 1'b0;
        end else begin
            r_vld     <= n_vld;
            o_res_stb <= i_ctrl.emit;
            if (i_ctrl.insert) begin
                if (full) begin
                    r_dropped <= 1'b1;
                end else begin
                    r_count <= r_count + CW'(1);
                end
            end else if (i_ctrl.emit) begin
                if (i_ctrl.final_job) begin
                    r_count   <= '0;
                    r_dropped <= 1'b0;
                    r_clock   <= '0;
                end else begin
                    r_count <= r_count - CW'(1);
                    r_clock <= turn;
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> design/priority_schedule_wait_times_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Nonpreemptive priority scheduler. Each word taken with start while busy is
// low is one job; it is inserted into a sorted chain of MAX_JOBS cells, so
// jobs load back to back. The word with last set closes the batch: busy then
// stays high until every stored job has left, while the chain shifts out one
// job per cycle, lowest priority value first and equal priorities in arrival
// order. Each result word is registered onto o_res at the edge at which it
// leaves the chain, marked by o_res_stb; the first result is registered once
// the controller has moved into its emit state after the word with last. The
// receiver cannot hold results off and must take one word per cycle. Jobs beyond
// MAX_JOBS are dropped and set the overflow bit on every result of that batch.
module priority_schedule_wait_times_top #(
    parameter int MAX_JOBS = psw_pkg::MAX_JOBS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      start,
    input  psw_pkg::t_in   i_job,
    output logic           busy,
    output psw_pkg::t_out  o_res,
    output logic           o_res_stb
);
    import psw_pkg::*;

    t_ctrl ctrl;
    t_stat stat;

    psw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_last  (i_job.last),
        .i_stat  (stat),
        .o_ctrl  (ctrl),
        .busy    (busy)
    );

    psw_datapath #(
        .MAX_JOBS (MAX_JOBS)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job     (i_job),
        .i_ctrl    (ctrl),
        .o_stat    (stat),
        .o_res     (o_res),
        .o_res_stb (o_res_stb)
    );

endmodule

`default_nettype wire
